// ----- rtl/umq_pkg.sv -----
// Shared types and codes for the undoable minimum queue.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package umq_pkg;

   // Request codes
   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_UNDO  = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_NOUNDO = 2'd3;

   // History record kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] min_value;
      logic [1:0]  status;
   } rsp_word_type;

   // One undo record
   typedef struct packed {
      logic        kind;
      logic [31:0] value;
   } hist_rec_type;

   // Broadcast control for the entry cells
   typedef struct packed {
      logic pop_shift;    // every cell takes its back neighbor's value
      logic unpop_shift;  // every cell takes its front neighbor's value
      logic push;         // the tail cell takes the pushed value
   } entry_ctl_type;

   // Broadcast control for the history cells
   typedef struct packed {
      logic record;       // shift a new record in at the top
      logic unrecord;     // shift the top record out
   } hist_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/undoable_min_queue.sv -----
// Undoable minimum queue: top level with control, counters and the rows of
// entry cells and history cells. Depends on umq_pkg, umq_entry_cell, umq_hist_cell.
// Push, pop and undo: result registered in the cycle after the request word, one word per
// cycle while responses are taken. Query on a non-empty queue: a token walks the QUEUE_DEPTH
// entry cells, one per cycle, and no new request is taken until the scan is done.
// Synchronous active-high reset empties the queue and history; stored values stay undefined.
`default_nettype none

module undoable_min_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HISTORY_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire umq_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output umq_pkg::rsp_word_type      rsp_word
);

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);

   umq_pkg::state_type state_ff, state_in;

   logic [QCNT_W-1:0] entry_count_ff, entry_count_in;
   logic [HCNT_W-1:0] hist_count_ff, hist_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   umq_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic req_accept;
   logic is_query;
   logic queue_empty;
   logic queue_full;
   logic scan_start;
   logic scan_done;

   umq_pkg::entry_ctl_type entry_ctl;
   umq_pkg::hist_ctl_type  hist_ctl;
   umq_pkg::hist_rec_type  new_rec;

   logic [31:0]           cell_value [QUEUE_DEPTH];
   logic                  cell_tok   [QUEUE_DEPTH];
   logic [31:0]           cell_min   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] tail_sel;
   logic [QUEUE_DEPTH-1:0] active;
   umq_pkg::hist_rec_type hist_rec   [HISTORY_DEPTH];

   assign queue_empty = (entry_count_ff == '0);
   assign queue_full  = (entry_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign is_query    = (req_word.req_type == umq_pkg::REQ_QUERY);
   assign req_accept  = req_valid && req_ready;
   assign scan_done   = cell_tok[QUEUE_DEPTH-1];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         umq_pkg::ST_IDLE: begin
            if (req_accept && is_query && !queue_empty) begin
               state_in = umq_pkg::ST_SCAN;
            end
         end
         umq_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = umq_pkg::ST_IDLE;
            end
         end
         default: state_in = umq_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready  = 1'b0;
      scan_start = 1'b0;
      unique case (state_ff)
         umq_pkg::ST_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            scan_start = req_accept && is_query && !queue_empty;
         end
         umq_pkg::ST_SCAN: begin
            req_ready = 1'b0;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Decode the request word into cell controls, counts and the result word, or capture the scan result
   always_comb begin
      entry_ctl      = '0;
      hist_ctl       = '0;
      new_rec.kind   = umq_pkg::KIND_PUSH;
      new_rec.value  = '0;
      entry_count_in = entry_count_ff;
      hist_count_in  = hist_count_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (req_accept) begin
         rsp_word_in.min_value = '0;
         rsp_word_in.status    = umq_pkg::STATUS_OK;
         unique case (req_word.req_type)
            umq_pkg::REQ_PUSH: begin
               rsp_valid_in = 1'b1;
               if (queue_full) begin
                  rsp_word_in.status = umq_pkg::STATUS_FULL;
               end else begin
                  entry_ctl.push  = 1'b1;
                  entry_count_in  = entry_count_ff + 1'b1;
                  hist_ctl.record = 1'b1;
               end
            end
            umq_pkg::REQ_POP: begin
               rsp_valid_in = 1'b1;
               if (queue_empty) begin
                  rsp_word_in.status = umq_pkg::STATUS_EMPTY;
               end else begin
                  entry_ctl.pop_shift = 1'b1;
                  entry_count_in      = entry_count_ff - 1'b1;
                  hist_ctl.record     = 1'b1;
                  new_rec.kind        = umq_pkg::KIND_POP;
                  new_rec.value       = cell_value[0];
               end
            end
            umq_pkg::REQ_UNDO: begin
               rsp_valid_in = 1'b1;
               if (hist_count_ff == '0) begin
                  rsp_word_in.status = umq_pkg::STATUS_NOUNDO;
               end else if (hist_rec[0].kind == umq_pkg::KIND_PUSH) begin
                  if (queue_empty) begin
                     rsp_word_in.status = umq_pkg::STATUS_EMPTY;
                  end else begin
                     entry_count_in    = entry_count_ff - 1'b1;
                     hist_ctl.unrecord = 1'b1;
                     hist_count_in     = hist_count_ff - 1'b1;
                  end
               end else begin
                  if (queue_full) begin
                     rsp_word_in.status = umq_pkg::STATUS_FULL;
                  end else begin
                     entry_ctl.unpop_shift = 1'b1;
                     entry_count_in        = entry_count_ff + 1'b1;
                     hist_ctl.unrecord     = 1'b1;
                     hist_count_in         = hist_count_ff - 1'b1;
                  end
               end
            end
            umq_pkg::REQ_QUERY: begin
               if (queue_empty) begin
                  rsp_valid_in       = 1'b1;
                  rsp_word_in.status = umq_pkg::STATUS_EMPTY;
               end
            end
            default: rsp_valid_in = 1'b1;
         endcase
         // A new record saturates the count; the oldest falls off the row
         if (hist_ctl.record && (hist_count_ff != HCNT_W'(HISTORY_DEPTH))) begin
            hist_count_in = hist_count_ff + 1'b1;
         end
      end else if (scan_done) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in.min_value = cell_min[QUEUE_DEPTH-1];
         rsp_word_in.status    = umq_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= umq_pkg::ST_IDLE;
         entry_count_ff <= '0;
         hist_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         hist_count_ff  <= hist_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // Row of entry cells: cell 0 is the front of the queue
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic        tok_in;
      logic [31:0] min_in;

      assign tail_sel[i] = (entry_count_ff == QCNT_W'(i));
      assign active[i]   = (QCNT_W'(i) < entry_count_ff);

      if (i == 0) begin : g_head
         assign front_value = hist_rec[0].value;
         assign tok_in      = scan_start;
         assign min_in      = '1;
      end else begin : g_body
         assign front_value = cell_value[i-1];
         assign tok_in      = cell_tok[i-1];
         assign min_in      = cell_min[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign back_value = cell_value[i];
      end else begin : g_inner
         assign back_value = cell_value[i+1];
      end

      umq_entry_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (entry_ctl),
         .push_value   (req_word.push_value),
         .front_value  (front_value),
         .back_value   (back_value),
         .tail_sel     (tail_sel[i]),
         .active       (active[i]),
         .scan_tok_in  (tok_in),
         .scan_min_in  (min_in),
         .value        (cell_value[i]),
         .scan_tok_out (cell_tok[i]),
         .scan_min_out (cell_min[i])
      );
   end

   // Row of history cells: cell 0 is the latest record
   for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_hist
      umq_pkg::hist_rec_type above_rec;
      umq_pkg::hist_rec_type below_rec;

      if (j == 0) begin : g_top
         assign above_rec = new_rec;
      end else begin : g_body
         assign above_rec = hist_rec[j-1];
      end

      if (j == HISTORY_DEPTH - 1) begin : g_bottom
         assign below_rec = hist_rec[j];
      end else begin : g_inner
         assign below_rec = hist_rec[j+1];
      end

      umq_hist_cell u_cell (
         .clock     (clock),
         .ctl       (hist_ctl),
         .above_rec (above_rec),
         .below_rec (below_rec),
         .rec       (hist_rec[j])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/umq_entry_cell.sv -----
// One queue entry cell: holds a value, shifts with its neighbors and takes
// part in the minimum scan chain. Depends on umq_pkg.
`default_nettype none

module umq_entry_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire umq_pkg::entry_ctl_type ctl,
   input  wire logic [31:0]           push_value,
   input  wire logic [31:0]           front_value,
   input  wire logic [31:0]           back_value,
   input  wire logic                  tail_sel,
   input  wire logic                  active,
   input  wire logic                  scan_tok_in,
   input  wire logic [31:0]           scan_min_in,
   output logic [31:0]                value,
   output logic                       scan_tok_out,
   output logic [31:0]                scan_min_out
);

   logic [31:0] value_ff;
   logic [31:0] value_in;
   logic        scan_tok_ff;
   logic [31:0] scan_min_ff;
   logic [31:0] scan_min_in_sel;

   // Select the next held value
   always_comb begin
      value_in = value_ff;
      if (ctl.pop_shift) begin
         value_in = back_value;
      end else if (ctl.unpop_shift) begin
         value_in = front_value;
      end else if (ctl.push && tail_sel) begin
         value_in = push_value;
      end
   end

   // Fold this cell into the running minimum when it holds a live entry
   always_comb begin
      if (active && (value_ff < scan_min_in)) begin
         scan_min_in_sel = value_ff;
      end else begin
         scan_min_in_sel = scan_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_tok_ff <= 1'b0;
      end else begin
         scan_tok_ff <= scan_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (scan_tok_in) begin
         scan_min_ff <= scan_min_in_sel;
      end
   end

   assign value        = value_ff;
   assign scan_tok_out = scan_tok_ff;
   assign scan_min_out = scan_min_ff;

endmodule

`default_nettype wire

// ----- rtl/umq_hist_cell.sv -----
// One undo history cell: a stage of the history stack, shifting down on a
// new record and up on an undo. Depends on umq_pkg.
`default_nettype none

module umq_hist_cell (
   input  wire logic                  clock,
   input  wire umq_pkg::hist_ctl_type ctl,
   input  wire umq_pkg::hist_rec_type above_rec,
   input  wire umq_pkg::hist_rec_type below_rec,
   output umq_pkg::hist_rec_type      rec
);

   umq_pkg::hist_rec_type rec_ff;
   umq_pkg::hist_rec_type rec_in;

   // Push down on record, pull up on undo, hold otherwise
   always_comb begin
      rec_in = rec_ff;
      if (ctl.record) begin
         rec_in = above_rec;
      end else if (ctl.unrecord) begin
         rec_in = below_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

`default_nettype wire

// ----- bench/undoable_min_queue_tb.sv -----
// Self-checking bench for undoable_min_queue: directed corner words, then biased random traffic.
// A scoreboard class mirrors queue and undo history; depends on umq_pkg and the RTL top level.
`default_nettype none

module undoable_min_queue_tb;

   localparam int QUEUE_SLOTS   = 16;
   localparam int HISTORY_SLOTS = 16;
   localparam int RANDOM_ITEMS  = 1075;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;

   // Mirror of the queue and its undo history, plus the words still owed by the block
   class umq_scoreboard;
      logic [31:0]           held [QUEUE_SLOTS];
      logic [3:0]            head;
      logic [4:0]            fill;
      logic                  hist_kind [HISTORY_SLOTS];
      logic [31:0]           hist_val [HISTORY_SLOTS];
      logic [3:0]            hist_top;
      logic [4:0]            hist_fill;
      umq_pkg::rsp_word_type expected_rsps [$];
      int                    errors;
      int                    kinds_sent [4];
      int                    statuses_seen [4];

      function new();
         head      = '0;
         fill      = '0;
         hist_top  = '0;
         hist_fill = '0;
         errors    = 0;
         foreach (kinds_sent[i]) kinds_sent[i] = 0;
         foreach (statuses_seen[i]) statuses_seen[i] = 0;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function void push_record(logic kind, logic [31:0] value);
         hist_kind[hist_top] = kind;
         hist_val[hist_top]  = value;
         hist_top = hist_top + 4'd1;
         if (hist_fill < HISTORY_SLOTS) hist_fill = hist_fill + 5'd1;
      endfunction

      // Advance the mirror by one accepted request word and queue the owed response
      function void note_request(umq_pkg::req_word_type w);
         umq_pkg::rsp_word_type want;
         logic [3:0]            slot;
         logic [31:0]           lowest;
         want.min_value = '0;
         want.status    = umq_pkg::STATUS_OK;
         kinds_sent[w.req_type]++;
         case (w.req_type)
            umq_pkg::REQ_PUSH: begin
               if (fill == QUEUE_SLOTS) begin
                  want.status = umq_pkg::STATUS_FULL;
               end else begin
                  held[head + fill[3:0]] = w.push_value;
                  fill = fill + 5'd1;
                  push_record(umq_pkg::KIND_PUSH, '0);
               end
            end
            umq_pkg::REQ_POP: begin
               if (fill == 0) begin
                  want.status = umq_pkg::STATUS_EMPTY;
               end else begin
                  push_record(umq_pkg::KIND_POP, held[head]);
                  head = head + 4'd1;
                  fill = fill - 5'd1;
               end
            end
            umq_pkg::REQ_UNDO: begin
               slot = hist_top - 4'd1;
               if (hist_fill == 0) begin
                  want.status = umq_pkg::STATUS_NOUNDO;
               end else if (hist_kind[slot] == umq_pkg::KIND_PUSH && fill == 0) begin
                  want.status = umq_pkg::STATUS_EMPTY;
               end else if (hist_kind[slot] == umq_pkg::KIND_POP && fill == QUEUE_SLOTS) begin
                  want.status = umq_pkg::STATUS_FULL;
               end else begin
                  // drop the back entry, or put the popped value back at the front
                  if (hist_kind[slot] == umq_pkg::KIND_PUSH) begin
                     fill = fill - 5'd1;
                  end else begin
                     head = head - 4'd1;
                     held[head] = hist_val[slot];
                     fill = fill + 5'd1;
                  end
                  hist_top  = slot;
                  hist_fill = hist_fill - 5'd1;
               end
            end
            default: begin
               if (fill == 0) begin
                  want.status = umq_pkg::STATUS_EMPTY;
               end else begin
                  lowest = 32'hFFFF_FFFF;
                  for (int i = 0; i < fill; i++) begin
                     if (held[head + 4'(i)] < lowest) lowest = held[head + 4'(i)];
                  end
                  want.min_value = lowest;
               end
            end
         endcase
         expected_rsps.insert(expected_rsps.size(), want);
      endfunction

      // Compare one accepted response word with the oldest owed one
      function void check_response(umq_pkg::rsp_word_type got);
         umq_pkg::rsp_word_type want;
         if (expected_rsps.size() == 0) begin
            $error("response word %h arrived with nothing expected", got);
            errors++;
            return;
         end
         want = expected_rsps[0];
         expected_rsps.delete(0);
         statuses_seen[want.status]++;
         if (got.min_value !== want.min_value) begin
            $error("min_value: expected %h, actual %h", want.min_value, got.min_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   umq_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   umq_pkg::rsp_word_type rsp_word;

   umq_scoreboard board;
   bit            calm;
   int            cycle_count;

   undoable_min_queue #(
      .QUEUE_DEPTH   (QUEUE_SLOTS),
      .HISTORY_DEPTH (HISTORY_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Accept response words, stalling at random outside the calm stretch
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_word);
      rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 15);
   end

   // Skew values toward the extremes and small numbers so that ties and minima matter
   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(7);
      case (r)
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // Offer one request word, idling first at random, and hold it until accepted
   task automatic send_req(input logic [1:0] kind, input logic [31:0] value);
      umq_pkg::req_word_type w;
      w.req_type   = kind;
      w.push_value = value;
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(w);
   endtask

   // Hold the sender until every owed response has arrived
   task automatic wait_for_drain();
      if (board.pending() > 0) begin
         req_valid <= 1'b0;
         while (board.pending() > 0) @(posedge clock);
      end
   endtask

   initial begin
      int unsigned r;
      int          mix;
      int          burst_left;
      logic [1:0]  kind;

      board     = new();
      calm      = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      rsp_ready <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty queue and empty history
      send_req(umq_pkg::REQ_POP, $urandom);
      send_req(umq_pkg::REQ_QUERY, $urandom);
      send_req(umq_pkg::REQ_UNDO, $urandom);
      // Extreme values, a query, then pop and undo the pop
      send_req(umq_pkg::REQ_PUSH, 32'h0000_0000);
      send_req(umq_pkg::REQ_PUSH, 32'hFFFF_FFFF);
      send_req(umq_pkg::REQ_QUERY, $urandom);
      send_req(umq_pkg::REQ_POP, $urandom);
      send_req(umq_pkg::REQ_UNDO, $urandom);
      // Fill the queue and the history, then push into a full queue and query
      repeat (QUEUE_SLOTS - 2) send_req(umq_pkg::REQ_PUSH, pick_value());
      send_req(umq_pkg::REQ_PUSH, pick_value());
      send_req(umq_pkg::REQ_QUERY, $urandom);
      // Pop with a full history drops the oldest record
      send_req(umq_pkg::REQ_POP, $urandom);
      send_req(umq_pkg::REQ_UNDO, $urandom);

      // Random bursts, each biased toward filling, draining, undoing or an even mix
      mix        = 0;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 650);
         if (n == 700) wait_for_drain();
         if (burst_left == 0) begin
            mix        = $urandom_range(3);
            burst_left = $urandom_range(40, 8);
            if ($urandom_range(7) == 0) wait_for_drain();
         end
         burst_left--;
         r = $urandom_range(99);
         case (mix)
            0:       kind = (r < 55) ? umq_pkg::REQ_PUSH : (r < 65) ? umq_pkg::REQ_POP :
                            (r < 80) ? umq_pkg::REQ_UNDO : umq_pkg::REQ_QUERY;
            1:       kind = (r < 15) ? umq_pkg::REQ_PUSH : (r < 60) ? umq_pkg::REQ_POP :
                            (r < 75) ? umq_pkg::REQ_UNDO : umq_pkg::REQ_QUERY;
            2:       kind = (r < 25) ? umq_pkg::REQ_PUSH : (r < 45) ? umq_pkg::REQ_POP :
                            (r < 85) ? umq_pkg::REQ_UNDO : umq_pkg::REQ_QUERY;
            default: kind = 2'(r % 4);
         endcase
         send_req(kind, (kind == umq_pkg::REQ_PUSH) ? pick_value() : $urandom);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Let the last words out, then settle
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d push, %0d pop, %0d undo and %0d query words.",
               board.kinds_sent[umq_pkg::REQ_PUSH], board.kinds_sent[umq_pkg::REQ_POP],
               board.kinds_sent[umq_pkg::REQ_UNDO], board.kinds_sent[umq_pkg::REQ_QUERY]);
      $display("Responses by status: ok %0d, empty %0d, full %0d, nothing to undo %0d.",
               board.statuses_seen[umq_pkg::STATUS_OK],
               board.statuses_seen[umq_pkg::STATUS_EMPTY],
               board.statuses_seen[umq_pkg::STATUS_FULL],
               board.statuses_seen[umq_pkg::STATUS_NOUNDO]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
